### design/vrt_pkg.sv
// Shared types and codes for the voxel ray traversal block.
// No dependencies; used by every module of the block but vrt_div.
`default_nettype none
package vrt_pkg;

  localparam int CoordW = 16;
  localparam int FieldW = 32;

  typedef enum logic [1:0] {
    ST_START = 2'd0,
    ST_QUERY = 2'd1,
    ST_HIT   = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ANSWER = 1'b1
  } op_t;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_POS  = 2'd1;
  localparam logic [1:0] STEP_NEG  = 2'd3;

  typedef struct packed {
    op_t                  op;
    logic [2:0][FieldW-1:0] origin;
    logic [2:0][FieldW-1:0] dir;
    logic [FieldW-1:0]    max_distance;
    logic                 hit;
  } cmd_t;

endpackage
`default_nettype wire

### design/vrt_front.sv
// Front end: accepts input beats, tags the command kind, two-entry queue.
// Depends on vrt_pkg.
`default_nettype none
module vrt_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_origin_x,
  input  wire logic [31:0] in_origin_y,
  input  wire logic [31:0] in_origin_z,
  input  wire logic [31:0] in_dir_x,
  input  wire logic [31:0] in_dir_y,
  input  wire logic [31:0] in_dir_z,
  input  wire logic [31:0] in_max_distance,
  input  wire logic        in_hit_answer,
  output logic             q_valid,
  output vrt_pkg::cmd_t    q_data,
  input  wire logic        q_pop
);

  vrt_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  vrt_pkg::cmd_t cmd;
  logic          push;

  always_comb begin
    cmd.op           = in_op ? vrt_pkg::OP_ANSWER : vrt_pkg::OP_START;
    cmd.origin       = {in_origin_z, in_origin_y, in_origin_x};
    cmd.dir          = {in_dir_z, in_dir_y, in_dir_x};
    cmd.max_distance = in_max_distance;
    cmd.hit          = in_hit_answer;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

### design/vrt_div.sv
// Restoring divider, one quotient bit per cycle.
// No package dependency.
`default_nettype none
module vrt_div #(
  parameter int NW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [31:0]   den,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r;
  logic [31:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem_r, n_r[NW-1]};
  assign fits  = (trial >= {1'b0, den});
  assign busy  = busy_r;
  assign done  = done_r;
  assign quot  = n_r;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      rem_r <= 32'd0;
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      n_r   <= {n_r[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/vrt_back.sv
// Back end: ray setup through the shared divider, DDA stepping, result register.
// Depends on vrt_pkg and vrt_div.
`default_nettype none
module vrt_back #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire vrt_pkg::cmd_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_voxel_x,
  output logic [15:0]        out_voxel_y,
  output logic [15:0]        out_voxel_z,
  output logic [1:0]         out_normal_x,
  output logic [1:0]         out_normal_y,
  output logic [1:0]         out_normal_z,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int TW = INT_BITS + FRAC_BITS;
  localparam int NW = 2 * FRAC_BITS + 1;
  localparam int SW = (NW > TW) ? NW : TW;
  localparam int LW = (TW > 32) ? TW : 32;
  localparam logic [TW-1:0] TMAX   = '1;
  localparam logic [NW-1:0] ONE_SQ = {1'b1, {(2*FRAC_BITS){1'b0}}};
  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DLOAD = 5'b00010,
    S_DWAIT = 5'b00100,
    S_STEP  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r;
  logic [15:0]        cell_r   [3];
  logic [1:0]         step_r   [3];
  logic [TW-1:0]      ncross_r [3];
  logic [TW-1:0]      delta_r  [3];
  logic [31:0]        mag_r    [3];
  logic [FRAC_BITS:0] dist_r   [3];
  logic [31:0]        limit_r;
  logic [1:0]         face_r;
  logic               active_r;
  logic [1:0]         job_ax_r;
  logic               job_kind_r;
  logic               after_start_r;

  logic               out_valid_r;
  logic [15:0]        out_vox_r [3];
  logic [1:0]         out_norm_r [3];
  vrt_pkg::status_t   out_status_r;
  logic               out_last_r;

  // start setup per axis
  logic [15:0]        st_cell [3];
  logic [1:0]         st_step [3];
  logic [31:0]        st_mag  [3];
  logic [FRAC_BITS:0] st_dist [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      st_cell[a] = 16'($signed(q_data.origin[a]) >>> FRAC_BITS);
      st_mag[a]  = q_data.dir[a][31] ? 32'(32'd0 - q_data.dir[a]) : q_data.dir[a];
      st_dist[a] = q_data.dir[a][31] ? {1'b0, q_data.origin[a][FRAC_BITS-1:0]}
                                     : ONE_FX - {1'b0, q_data.origin[a][FRAC_BITS-1:0]};
      if (q_data.dir[a] == 32'd0)  st_step[a] = vrt_pkg::STEP_NONE;
      else if (q_data.dir[a][31])  st_step[a] = vrt_pkg::STEP_NEG;
      else                         st_step[a] = vrt_pkg::STEP_POS;
    end
  end

  // divider
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_quot;
  logic [SW-1:0] quot_x;
  logic [TW-1:0] quot_sat;

  assign div_start = (state_r == S_DLOAD);
  assign div_num   = job_kind_r ? ONE_SQ : {dist_r[job_ax_r], {FRAC_BITS{1'b0}}};
  assign quot_x    = SW'(div_quot);
  assign quot_sat  = (quot_x > SW'(TMAX)) ? TMAX : TW'(quot_x);

  vrt_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mag_r[job_ax_r]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // one DDA step: nearest crossing, ties to the later axis
  logic [1:0]    ax;
  logic [TW-1:0] m;
  logic          go;
  logic [TW:0]   sum;
  logic [TW-1:0] adv_cross;
  logic [15:0]   adv_cell;
  logic [1:0]    norm_cur [3];

  always_comb begin
    if (ncross_r[0] < ncross_r[1] && ncross_r[0] < ncross_r[2]) ax = 2'd0;
    else if (ncross_r[1] < ncross_r[2])                        ax = 2'd1;
    else                                                       ax = 2'd2;
    m         = ncross_r[ax];
    go        = !((LW'(m) >= LW'(limit_r)) || (m == TMAX));
    sum       = {1'b0, m} + {1'b0, delta_r[ax]};
    adv_cross = sum[TW] ? TMAX : sum[TW-1:0];
    case (step_r[ax])
      vrt_pkg::STEP_POS: adv_cell = cell_r[ax] + 16'd1;
      vrt_pkg::STEP_NEG: adv_cell = cell_r[ax] - 16'd1;
      default:           adv_cell = cell_r[ax];
    endcase
    for (int a = 0; a < 3; a++) begin
      norm_cur[a] = (face_r == 2'(a + 1)) ? 2'(2'd0 - step_r[a]) : 2'd0;
    end
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_r      <= 1'b0;
      face_r        <= 2'd0;
      limit_r       <= 32'd0;
      job_ax_r      <= 2'd0;
      job_kind_r    <= 1'b0;
      after_start_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cell_r[a]   <= 16'd0;
        step_r[a]   <= vrt_pkg::STEP_NONE;
        ncross_r[a] <= TMAX;
        delta_r[a]  <= TMAX;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.op == vrt_pkg::OP_START) begin
              for (int a = 0; a < 3; a++) begin
                cell_r[a] <= st_cell[a];
                step_r[a] <= st_step[a];
                mag_r[a]  <= st_mag[a];
                dist_r[a] <= st_dist[a];
              end
              limit_r    <= q_data.max_distance;
              face_r     <= 2'd0;
              job_ax_r   <= 2'd0;
              job_kind_r <= 1'b0;
              state_r    <= S_DLOAD;
            end else if (active_r) begin
              if (q_data.hit) begin
                for (int a = 0; a < 3; a++) begin
                  out_vox_r[a]  <= cell_r[a];
                  out_norm_r[a] <= norm_cur[a];
                end
                out_status_r  <= vrt_pkg::ST_HIT;
                out_last_r    <= 1'b1;
                out_valid_r   <= 1'b1;
                active_r      <= 1'b0;
                after_start_r <= 1'b0;
                state_r       <= S_OUT;
              end else begin
                state_r <= S_STEP;
              end
            end
          end
        end
        S_DLOAD: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (job_kind_r) delta_r[job_ax_r]  <= quot_sat;
            else            ncross_r[job_ax_r] <= quot_sat;
            job_kind_r <= ~job_kind_r;
            if (job_kind_r) job_ax_r <= job_ax_r + 2'd1;
            if (job_kind_r && job_ax_r == 2'd2) begin
              for (int a = 0; a < 3; a++) begin
                out_vox_r[a]  <= cell_r[a];
                out_norm_r[a] <= 2'd0;
              end
              out_status_r  <= vrt_pkg::ST_START;
              out_last_r    <= 1'b0;
              out_valid_r   <= 1'b1;
              active_r      <= 1'b0;
              after_start_r <= 1'b1;
              state_r       <= S_OUT;
            end else begin
              state_r <= S_DLOAD;
            end
          end
        end
        S_STEP: begin
          after_start_r <= 1'b0;
          out_valid_r   <= 1'b1;
          state_r       <= S_OUT;
          if (go) begin
            cell_r[ax]   <= adv_cell;
            ncross_r[ax] <= adv_cross;
            face_r       <= 2'(ax + 2'd1);
            active_r     <= 1'b1;
            for (int a = 0; a < 3; a++) begin
              out_vox_r[a]  <= (2'(a) == ax) ? adv_cell : cell_r[a];
              out_norm_r[a] <= (2'(a) == ax) ? 2'(2'd0 - step_r[a]) : 2'd0;
            end
            out_status_r <= vrt_pkg::ST_QUERY;
            out_last_r   <= 1'b0;
          end else begin
            active_r <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              out_vox_r[a]  <= cell_r[a];
              out_norm_r[a] <= 2'd0;
            end
            out_status_r <= vrt_pkg::ST_MISS;
            out_last_r   <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= after_start_r ? S_STEP : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_voxel_x  = out_vox_r[0];
  assign out_voxel_y  = out_vox_r[1];
  assign out_voxel_z  = out_vox_r[2];
  assign out_normal_x = out_norm_r[0];
  assign out_normal_y = out_norm_r[1];
  assign out_normal_z = out_norm_r[2];
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

  a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result shown outside output state");
  a_last_ends_ray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !active_r) else $error("ray active after last beat");
  a_query_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == vrt_pkg::ST_QUERY) |-> active_r)
    else $error("query without active ray");
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DWAIT) else $error("divider busy outside wait state");

endmodule
`default_nettype wire

### design/voxel_ray_traversal_unit.sv
// Top level of the 3D voxel ray traversal (DDA) block.
// Depends on vrt_pkg, vrt_front, vrt_back (which holds vrt_div).
//
// Usage:
//  - Input channel (in_valid/in_ready): a beat with in_op = 0 starts a ray
//    from origin, direction and max distance (Q fixed point); in_op = 1
//    answers the last query with in_hit_answer.
//  - Result channel (out_valid/out_ready): voxel, entry normal, status, last.
//    A start gives two beats (start voxel, then first query or miss);
//    an answer gives one beat (hit, next query or miss); an answer with no
//    live ray gives none.
//  - Input beats land in a two-entry queue, so the source keeps going while
//    a result waits on the receiver.
//  - Start: the shared one-bit-per-cycle divider forms three first crossings
//    and three deltas, one after another, before the start beat.
//  - Answer: pop, compare-and-add step, output; a hit answer goes from the
//    pop straight to output.
//  - A stalled receiver holds the output register; the back end waits and the
//    queue fills, then in_ready drops.
//  - Reset (rst_n low, synchronous) empties the queue and clears ray state.
`default_nettype none
module voxel_ray_traversal_unit #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_origin_x,
  input  wire logic [31:0] in_origin_y,
  input  wire logic [31:0] in_origin_z,
  input  wire logic [31:0] in_dir_x,
  input  wire logic [31:0] in_dir_y,
  input  wire logic [31:0] in_dir_z,
  input  wire logic [31:0] in_max_distance,
  input  wire logic        in_hit_answer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_voxel_x,
  output logic [15:0]      out_voxel_y,
  output logic [15:0]      out_voxel_z,
  output logic [1:0]       out_normal_x,
  output logic [1:0]       out_normal_y,
  output logic [1:0]       out_normal_z,
  output logic [1:0]       out_status,
  output logic             out_last
);

  logic          q_valid, q_pop;
  vrt_pkg::cmd_t q_data;

  // accept and tag beats
  vrt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_origin_z     (in_origin_z),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .in_max_distance (in_max_distance),
    .in_hit_answer   (in_hit_answer),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop)
  );

  // setup, stepping and result register
  vrt_back #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_voxel_x  (out_voxel_x),
    .out_voxel_y  (out_voxel_y),
    .out_voxel_z  (out_voxel_z),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire
